// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted (active-low reset).
`define RBSI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbsi assertion failed");

// Clocked assertion that is also checked during reset.
`define RBSI_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rbsi assertion failed");

`endif

// ===== rtl/rbsi_pkg.sv =====
// Shared types and register index codes for the ray/box slab test.
`default_nettype none

package rbsi_pkg;

    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BOX_MIN_X = 3'd0;
    localparam t_cfg_idx REG_BOX_MIN_Y = 3'd1;
    localparam t_cfg_idx REG_BOX_MIN_Z = 3'd2;
    localparam t_cfg_idx REG_BOX_MAX_X = 3'd3;
    localparam t_cfg_idx REG_BOX_MAX_Y = 3'd4;
    localparam t_cfg_idx REG_BOX_MAX_Z = 3'd5;

    localparam int NUM_AXES = 3;
    localparam int NUM_DIVS = 6;

endpackage

`default_nettype wire

// ===== rtl/rbsi_slab_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
`default_nettype none

module rbsi_slab_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo
);
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    genvar k;
    for (k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W:0]   diff;
        logic             qbit;
        logic [DEN_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
        end

        assign shifted = {rem_in, num_in[NUM_W-1-k]};
        assign diff    = shifted - {1'b0, den_in};
        assign qbit    = (shifted >= {1'b0, den_in});
        // remainder stays below the divisor, so it fits DEN_W bits
        assign n_rem   = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= {quo_in[NUM_W-2:0], qbit};
                r_num[k] <= num_in;
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/ray_box_slab_intersect.sv =====
// Top level: pipelined slab test of one ray against a configured box.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  cfg     | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data (box corners)
//  ray     | in  | i_valid/o_stall        | origin xyz, dir xyz, max_dist
//  result  | out | o_valid/i_stall        | hit, clamped_entry, entry_t, exit_t
//
// One item per cycle sustained while the output is not stalled. The pipeline runs
// through the input register, the six bit-per-stage slab dividers, stages A and B and the output register.
// Reset (i_rst_n low, synchronous) clears the box registers and all valid bits.
// A stall on the output freezes the whole pipeline; o_stall = o_valid & i_stall.
// Config writes are always taken (o_cfg_ready high); write only while idle.
`default_nettype none

module ray_box_slab_intersect #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire rbsi_pkg::t_cfg_idx            i_cfg_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_cfg_data,
    // ray items
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_max_dist,
    // result items
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_clamped_entry,
    output logic signed [COORD_WIDTH-1:0]      o_entry_t,
    output logic signed [COORD_WIDTH-1:0]      o_exit_t
);
    import rbsi_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int NUM_W = COORD_WIDTH + FRAC_BITS;

    localparam logic signed [CW-1:0] NEG_ONE = -(CW'(1) << FRAC_BITS);
    localparam logic signed [CW-1:0] T_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] T_MIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic [NUM_W-1:0]     LIM     = NUM_W'(1) << (CW - 1);

    typedef struct packed {
        logic                     valid;
        logic [NUM_AXES-1:0]      dir_zero;
        logic [NUM_DIVS-1:0]      neg;
        logic signed [CW-1:0]     max_d;
    } t_side;

    // global advance: the output register is free or being taken
    logic en;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = o_valid && i_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------- box registers ----------------
    logic signed [CW-1:0] r_box [NUM_DIVS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_DIVS; j++) r_box[j] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BOX_MIN_X: r_box[0] <= i_cfg_data;
                REG_BOX_MIN_Y: r_box[1] <= i_cfg_data;
                REG_BOX_MIN_Z: r_box[2] <= i_cfg_data;
                REG_BOX_MAX_X: r_box[3] <= i_cfg_data;
                REG_BOX_MAX_Y: r_box[4] <= i_cfg_data;
                REG_BOX_MAX_Z: r_box[5] <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- stage 0: differences and magnitudes ----------------
    logic signed [CW-1:0] org [NUM_AXES];
    logic signed [CW-1:0] dir [NUM_AXES];
    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    logic [NUM_W-1:0] n_num [NUM_DIVS];
    logic [CW-1:0]    n_den [NUM_DIVS];
    t_side            n_s0;

    always_comb begin
        logic signed [CW:0] diff;
        logic               nneg;
        logic [CW-1:0]      nmag;
        logic [CW-1:0]      dmag;
        n_s0.valid = i_valid;
        n_s0.max_d = i_max_dist;
        for (int j = 0; j < NUM_DIVS; j++) begin
            diff = {r_box[j][CW-1], r_box[j]} - {org[j % 3][CW-1], org[j % 3]};
            nneg = diff[CW];
            nmag = nneg ? CW'(-diff) : diff[CW-1:0];
            dmag = dir[j % 3][CW-1] ? (~dir[j % 3] + CW'(1)) : dir[j % 3];
            n_num[j]    = {nmag, {FRAC_BITS{1'b0}}};
            n_den[j]    = dmag;
            n_s0.neg[j] = nneg ^ dir[j % 3][CW-1];
        end
        for (int a = 0; a < NUM_AXES; a++) n_s0.dir_zero[a] = (dir[a] == '0);
    end

    logic [NUM_W-1:0] r_num [NUM_DIVS];
    logic [CW-1:0]    r_den [NUM_DIVS];
    t_side            r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NUM_DIVS; j++) begin
                r_num[j] <= n_num[j];
                r_den[j] <= n_den[j];
            end
        end
    end

    // ---------------- dividers ----------------
    logic [NUM_W-1:0] quo [NUM_DIVS];

    genvar g;
    for (g = 0; g < NUM_DIVS; g++) begin : g_div
        rbsi_slab_div #(
            .NUM_W(NUM_W),
            .DEN_W(CW)
        ) u_div (
            .i_clk(i_clk),
            .i_en (en),
            .i_num(r_num[g]),
            .i_den(r_den[g]),
            .o_quo(quo[g])
        );
    end

    // side data rides alongside the divider stages
    t_side r_side [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) r_side[k].valid <= 1'b0;
        end else if (en) begin
            r_side[0] <= r_s0;
            for (int k = 1; k < NUM_W; k++) r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- stage A: saturate and sort ----------------
    t_side                r_a_side;
    logic signed [CW-1:0] r_a_t1 [NUM_AXES];
    logic signed [CW-1:0] r_a_t2 [NUM_AXES];
    logic signed [CW-1:0] n_a_t1 [NUM_AXES];
    logic signed [CW-1:0] n_a_t2 [NUM_AXES];

    always_comb begin
        logic signed [CW-1:0] t [NUM_DIVS];
        for (int j = 0; j < NUM_DIVS; j++) begin
            if (!r_side[NUM_W-1].neg[j]) begin
                t[j] = (quo[j] >= LIM) ? T_MAX : quo[j][CW-1:0];
            end else begin
                // q equal to the limit negates to the most negative value
                t[j] = (quo[j] > LIM) ? T_MIN : -quo[j][CW-1:0];
            end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
            if (t[a] > t[a+3]) begin
                n_a_t1[a] = t[a+3];
                n_a_t2[a] = t[a];
            end else begin
                n_a_t1[a] = t[a];
                n_a_t2[a] = t[a+3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side.valid <= 1'b0;
        end else if (en) begin
            r_a_side <= r_side[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_a_t1[a] <= n_a_t1[a];
                r_a_t2[a] <= n_a_t2[a];
            end
        end
    end

    // ---------------- stage B: merge X and Y, early checks ----------------
    logic                 r_b_valid;
    logic                 r_b_hit;
    logic                 r_b_zz;
    logic signed [CW-1:0] r_b_lmin, r_b_lmax, r_b_t1z, r_b_t2z, r_b_dist;
    logic                 n_b_hit;
    logic signed [CW-1:0] n_b_lmin, n_b_lmax;

    always_comb begin
        n_b_lmin = NEG_ONE;
        n_b_lmax = NEG_ONE;
        n_b_hit  = 1'b1;
        if (!r_a_side.dir_zero[0]) begin
            n_b_lmin = r_a_t1[0];
            n_b_lmax = r_a_t2[0];
            if (n_b_lmax < 0 || n_b_lmin > r_a_side.max_d) n_b_hit = 1'b0;
        end
        if (!r_a_side.dir_zero[1]) begin
            if (r_a_t1[1] > n_b_lmin) n_b_lmin = r_a_t1[1];
            if (r_a_t2[1] < n_b_lmax || n_b_lmax < 0) n_b_lmax = r_a_t2[1];
            if (n_b_lmax < 0 || n_b_lmin > r_a_side.max_d) n_b_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_hit  <= n_b_hit;
            r_b_zz   <= r_a_side.dir_zero[2];
            r_b_lmin <= n_b_lmin;
            r_b_lmax <= n_b_lmax;
            r_b_t1z  <= r_a_t1[2];
            r_b_t2z  <= r_a_t2[2];
            r_b_dist <= r_a_side.max_d;
        end
    end

    // ---------------- stage C: merge Z, final check, output register ----------------
    logic                 n_hit;
    logic signed [CW-1:0] n_lmin, n_lmax;

    always_comb begin
        n_lmin = r_b_lmin;
        n_lmax = r_b_lmax;
        if (!r_b_zz) begin
            if (r_b_t1z > n_lmin) n_lmin = r_b_t1z;
            if (r_b_t2z < n_lmax || n_lmax < 0) n_lmax = r_b_t2z;
        end
        n_hit = r_b_hit && (n_lmin <= n_lmax) && (n_lmax >= 0) && (n_lmin <= r_b_dist);
    end

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic signed [CW-1:0] r_out_clamped, r_out_entry, r_out_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit     <= n_hit;
            r_out_clamped <= (n_hit && n_lmin > 0) ? n_lmin : '0;
            r_out_entry   <= n_hit ? n_lmin : '0;
            r_out_exit    <= n_hit ? n_lmax : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_clamped_entry = r_out_clamped;
    assign o_entry_t       = r_out_entry;
    assign o_exit_t        = r_out_exit;

endmodule

`default_nettype wire

// ===== rtl/rbsi_checker.sv =====
// Port-level checker for the ray/box slab test, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module rbsi_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic                          o_hit,
    input wire logic signed [COORD_WIDTH-1:0] o_clamped_entry,
    input wire logic signed [COORD_WIDTH-1:0] o_entry_t,
    input wire logic signed [COORD_WIDTH-1:0] o_exit_t
);

    // pipeline empties on reset
    `RBSI_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid)

    // input back-pressure only comes from a held result
    `RBSI_ASSERT(a_stall_src, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall))

    // a miss carries all-zero distances
    `RBSI_ASSERT(a_miss_zero, i_clk, i_rst_n, (o_valid && !o_hit) |-> (o_entry_t == '0 && o_exit_t == '0 && o_clamped_entry == '0))

    // a hit has an ordered interval with a non-negative exit and clamped entry
    `RBSI_ASSERT(a_hit_order, i_clk, i_rst_n, (o_valid && o_hit) |-> (o_entry_t <= o_exit_t && o_exit_t >= 0 && o_clamped_entry >= 0))

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (.*);

`default_nettype wire

// ===== sim/ray_box_slab_intersect_tb.sv =====
// Self-checking testbench for the ray/box slab test: table, then random rays.
`default_nettype none

module ray_box_slab_intersect_tb;
    import rbsi_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + FB + 4;
    localparam logic signed [CW-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [CW-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [CW-1:0] Q_ONE = 32'sh00010000;

    typedef struct packed {
        logic signed [CW-1:0] org_x, org_y, org_z;
        logic signed [CW-1:0] dir_x, dir_y, dir_z;
        logic signed [CW-1:0] max_dist;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] clamped_entry;
        logic signed [CW-1:0] entry_t;
        logic signed [CW-1:0] exit_t;
    } t_hit_info;

    // one directed row: ray, plus an optional typed-in answer
    typedef struct packed {
        t_ray      ray;
        logic      has_answer;
        t_hit_info answer;
    } t_row;

    logic i_clk, i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cfg_idx i_cfg_index;
    logic signed [CW-1:0] i_cfg_data;
    logic i_valid, o_stall;
    logic signed [CW-1:0] i_origin_x, i_origin_y, i_origin_z;
    logic signed [CW-1:0] i_dir_x, i_dir_y, i_dir_z, i_max_dist;
    logic o_valid, i_stall, o_hit;
    logic signed [CW-1:0] o_clamped_entry, o_entry_t, o_exit_t;

    ray_box_slab_intersect dut (.*);

    // box copy held by the predictor
    logic signed [CW-1:0] box_lo [NUM_AXES];
    logic signed [CW-1:0] box_hi [NUM_AXES];

    t_hit_info pending_hits[$];
    int  mismatches;
    bit  rx_hold_long;   // sender raises for the long receiver hold-off
    bit  rx_quiet;       // stretches with no receiver stalls

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Saturating Q16.16 quotient (a - b) / d, truncating toward zero.
    function automatic logic signed [CW-1:0] slab_quot(logic signed [CW-1:0] a,
            logic signed [CW-1:0] b, logic signed [CW-1:0] d);
        logic signed [CW+1:0]   diff;
        logic signed [CW+FB+1:0] num;
        logic signed [CW+FB+1:0] q;
        diff = $signed({a[CW-1], a[CW-1], a}) - $signed({b[CW-1], b[CW-1], b});
        num  = $signed(diff) <<< FB;
        q    = num / $signed({{(FB+2){d[CW-1]}}, d});
        if (q > $signed({{(FB+2){1'b0}}, Q_MAX})) return Q_MAX;
        if (q < $signed({{(FB+2){1'b1}}, Q_MIN})) return Q_MIN;
        return q[CW-1:0];
    endfunction

    function automatic t_hit_info predict_hit(t_ray r);
        logic signed [CW-1:0] org [NUM_AXES];
        logic signed [CW-1:0] dir [NUM_AXES];
        logic signed [CW-1:0] t_near, t_far, t1, t2, tmp;
        logic      hit;
        t_hit_info res;
        org = '{r.org_x, r.org_y, r.org_z};
        dir = '{r.dir_x, r.dir_y, r.dir_z};
        t_near = -Q_ONE;
        t_far  = -Q_ONE;
        hit    = 1'b1;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            if (hit && dir[ax] != 0) begin
                t1 = slab_quot(box_lo[ax], org[ax], dir[ax]);
                t2 = slab_quot(box_hi[ax], org[ax], dir[ax]);
                if (t1 > t2) begin
                    tmp = t1; t1 = t2; t2 = tmp;
                end
                if (ax == 0) begin
                    t_near = t1;
                    t_far  = t2;
                end else begin
                    if (t1 > t_near) t_near = t1;
                    if (t2 < t_far || t_far < 0) t_far = t2;
                end
                // early-out after X and Y
                if (ax < 2 && (t_far < 0 || t_near > r.max_dist)) hit = 1'b0;
            end
        end
        if (hit && !(t_near <= t_far && t_far >= 0 && t_near <= r.max_dist)) hit = 1'b0;
        res = '0;
        if (hit) begin
            res.hit           = 1'b1;
            res.clamped_entry = (t_near > 0) ? t_near : '0;
            res.entry_t       = t_near;
            res.exit_t        = t_far;
        end
        return res;
    endfunction

    // Valid is left high; the caller drops it after the last write.
    task automatic write_box_reg(t_cfg_idx idx, logic signed [CW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < REG_BOX_MAX_X) box_lo[idx] = val;
        else                     box_hi[idx - REG_BOX_MAX_X] = val;
    endtask

    task automatic load_box(logic signed [CW-1:0] lx, ly, lz, hx, hy, hz);
        write_box_reg(REG_BOX_MIN_X, lx);
        write_box_reg(REG_BOX_MIN_Y, ly);
        write_box_reg(REG_BOX_MIN_Z, lz);
        write_box_reg(REG_BOX_MAX_X, hx);
        write_box_reg(REG_BOX_MAX_Y, hy);
        write_box_reg(REG_BOX_MAX_Z, hz);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every pending hit has come back, plus the pipe depth.
    task automatic drain;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Offer one ray; held until the block takes it.
    task automatic send_ray(t_ray r, t_hit_info typed, bit use_typed);
        t_hit_info pred;
        pred = predict_hit(r);
        if (use_typed && pred != typed)
            $display("table row disagrees with predictor: %h vs %h", typed, pred);
        i_valid    <= 1'b1;
        i_origin_x <= r.org_x;
        i_origin_y <= r.org_y;
        i_origin_z <= r.org_z;
        i_dir_x    <= r.dir_x;
        i_dir_y    <= r.dir_y;
        i_dir_z    <= r.dir_z;
        i_max_dist <= r.max_dist;
        do @(posedge i_clk); while (o_stall);
        pending_hits.push_back(use_typed ? typed : pred);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3, 4:    return $signed($urandom);
            default: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] rand_dir();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return $signed($urandom);
            2:       return Q_MIN;
            default: return $signed($urandom_range(1, 32'h00030000))
                            * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    function automatic t_ray rand_ray();
        t_ray r;
        r.org_x = rand_coord(); r.org_y = rand_coord(); r.org_z = rand_coord();
        r.dir_x = rand_dir();   r.dir_y = rand_dir();   r.dir_z = rand_dir();
        r.max_dist = ($urandom_range(0, 7) == 0) ? rand_coord()
                     : $signed($urandom_range(0, 32'h00200000));
        return r;
    endfunction

    // Receiver: own stall pattern, quiet stretches, one long hold-off.
    initial begin
        int hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold_long) begin
                i_stall <= 1'b1;
                for (hold = 0; hold < 4 * LATENCY; hold++) @(posedge i_clk);
                rx_hold_long = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result checker: samples at the edge where the item is taken.
    always @(posedge i_clk) begin
        t_hit_info got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_hit, o_clamped_entry, o_entry_t, o_exit_t};
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit || got.clamped_entry !== want.clamped_entry
                        || got.entry_t !== want.entry_t || got.exit_t !== want.exit_t) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hit %b/%b clamped %h/%h entry %h/%h exit %h/%h",
                            want.hit, got.hit, want.clamped_entry, got.clamped_entry,
                            want.entry_t, got.entry_t, want.exit_t, got.exit_t);
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        t_ray r;
        int   sent, burst, gap;
        bit   paused;
        mismatches   = 0;
        rx_hold_long = 1'b0;
        rx_quiet     = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_BOX_MIN_X;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        {i_origin_x, i_origin_y, i_origin_z} = '0;
        {i_dir_x, i_dir_y, i_dir_z, i_max_dist} = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            box_lo[a] = '0;
            box_hi[a] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the box is a point at the origin.
        // all directions zero: miss
        rows.push_back('{'{0, 0, 0, 0, 0, 0, Q_MAX}, 1'b1, '0});
        // along +x through the point box: entry = exit = 1.0
        rows.push_back('{'{-Q_ONE, 0, 0, Q_ONE, 0, 0, Q_MAX}, 1'b1,
                         '{1'b1, Q_ONE, Q_ONE, Q_ONE}});
        // same, but max_dist below entry: miss
        rows.push_back('{'{-Q_ONE, 0, 0, Q_ONE, 0, 0, 0}, 1'b1, '0});
        // ray moving away: exit negative, miss
        rows.push_back('{'{-Q_ONE, 0, 0, -Q_ONE, 0, 0, Q_MAX}, 1'b1, '0});
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].answer, rows[i].has_answer);
        i_valid <= 1'b0;
        drain();

        // Unit box, then extreme rows checked by the predictor.
        load_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        rows.delete();
        rows.push_back('{'{0, 0, 0, Q_ONE, Q_ONE, Q_ONE, Q_MAX}, 1'b0, '0});
        rows.push_back('{'{Q_MIN, 0, 0, Q_ONE, 0, 0, Q_MAX}, 1'b0, '0});
        rows.push_back('{'{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX}, 1'b0, '0});
        rows.push_back('{'{Q_MIN, Q_MIN, Q_MIN, 1, 1, 1, Q_MAX}, 1'b0, '0});
        rows.push_back('{'{0, 0, 0, 0, 0, Q_ONE, Q_MAX}, 1'b0, '0});
        rows.push_back('{'{0, Q_MAX, 0, Q_ONE, 0, 0, Q_MAX}, 1'b0, '0});
        rows.push_back('{'{0, 0, 0, 0, -Q_ONE, 0, Q_MIN}, 1'b0, '0});
        rows.push_back('{'{-32'sh30000, 0, 0, Q_ONE, Q_ONE, -Q_ONE, Q_ONE}, 1'b0, '0});
        rows.push_back('{'{0, 0, 0, -1, 1, Q_MAX, Q_MAX}, 1'b0, '0});
        foreach (rows[i]) send_ray(rows[i].ray, rows[i].answer, rows[i].has_answer);
        i_valid <= 1'b0;
        drain();

        // Random phases across box settings, extremes and an inverted box.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE);
                1: load_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
                2: load_box(Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE);
                3: load_box(Q_MAX, Q_MIN, 0, Q_MIN, Q_MAX, 0);
                default: load_box(rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord());
            endcase
            rx_quiet = (phase == 3);
            sent   = 0;
            paused = 1'b0;
            while (sent < 320) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && sent < 320; k++) begin
                    r = rand_ray();
                    send_ray(r, '0, 1'b0);
                    sent++;
                    if (phase == 1 && sent == 100) rx_hold_long = 1'b1;
                end
                if (phase == 2 && sent >= 160 && !paused) begin
                    // sender waits for every outstanding result
                    paused = 1'b1;
                    i_valid <= 1'b0;
                    do @(posedge i_clk); while (pending_hits.size() != 0);
                end else begin
                    gap = $urandom_range(0, 6);
                    if (gap != 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
            i_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
